>>> rtl/core/pdx_pkg.sv
// Package for the packet deframer with XOR check.
// Holds sizes, register indexes, the controller state type and the
// command and status structs shared by the controller and the datapath.
package pdx_pkg;

	// Payload buffer size and derived address width.
	localparam int PAYLOAD_DEPTH = 64;
	localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);

	// Field widths fixed by the interface.
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int ID_W   = 16;

	// Reset values of the configuration registers.
	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd170;
	localparam logic [LEN_W-1:0]  MAX_LEN_RST    = 7'd64;

	// Configuration register indexes.
	typedef enum logic {
		REG_START_BYTE = 1'b0,
		REG_MAX_LENGTH = 1'b1
	} reg_idx_t;

	// Input item kinds.
	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	// Parser phases, plus the emission run of a good packet.
	typedef enum logic [2:0] {
		ST_HUNT  = 3'd0,
		ST_ID_LO = 3'd1,
		ST_ID_HI = 3'd2,
		ST_LEN   = 3'd3,
		ST_DATA  = 3'd4,
		ST_CHECK = 3'd5,
		ST_EMIT  = 3'd6
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ld_id_lo;    // take the low id byte, seed the XOR
		logic ld_id_hi;    // take the high id byte
		logic ld_len;      // take the length, clear the fill count
		logic st_data;     // store a payload byte
		logic emit_start;  // rewind the count for the emission run
		logic emit_empty;  // present the result of an empty packet
		logic rd_issue;    // read the next payload byte for output
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic start_match; // byte equals the start byte
		logic len_bad;     // length byte beyond the effective limit
		logic rx_zero;     // received byte is zero
		logic len_zero;    // stored length is zero
		logic count_last;  // the count points at the final payload byte
		logic xor_ok;      // byte equals the running XOR
		logic rd_ready;    // the read stage can take a new byte
		logic pipe_empty;  // no result held in the read or output stage
	} status_t;

endpackage

>>> rtl/core/packet_deframer_xor_check.sv
// Packet deframer with XOR check: receives serial bytes and line errors
// and emits the payload bytes of frames whose checksum is good.
// Instantiates pdx_ctrl and pdx_datapath; depends on pdx_pkg.
//
// Input channel: one item per byte (kind 0) or line error (kind 1),
// taken when in_valid is high and in_stall low. While a frame is parsed
// an item is taken every cycle. After a good checksum byte of a non-empty
// packet the input is stalled while the payload buffer is read out at one
// byte per cycle when the receiver does not stall. Each payload byte passes
// through the read stage into the output register; the single result of
// an empty packet is loaded straight into the output register. The rate of
// the run is set by the single read port of the payload buffer.
// Output channel: out_valid with out_stall from the receiver. A stalled
// result holds; the emission run waits behind it, and a checksum byte is
// not taken while results of the previous packet are still held.
// Configuration: cfg_we with cfg_index (0 start byte, 1 maximum length)
// and cfg_data, written only while the block is idle, a rule binding the
// user that the block does not enforce. Reset clears the parser to the
// hunt for a start byte and the registers to start byte 170 and maximum
// length 64; the payload buffer is not cleared and needs no clearing pass.
module packet_deframer_xor_check import pdx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [BYTE_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [BYTE_W-1:0] rx_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ID_W-1:0]   packet_id,
	output logic [LEN_W-1:0]  packet_length,
	output logic [ADDR_W-1:0] byte_index,
	output logic [BYTE_W-1:0] payload_byte,
	output logic              has_payload,
	output logic              last
);

	cmd_t    cmd;
	status_t sts;

	// Controller.
	pdx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath.
	pdx_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_data       (rx_data),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.packet_id     (packet_id),
		.packet_length (packet_length),
		.byte_index    (byte_index),
		.payload_byte  (payload_byte),
		.has_payload   (has_payload),
		.last          (last)
	);

`ifndef SYNTHESIS
	// An empty-packet result is only produced into an empty output path.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_empty |-> sts.pipe_empty)
		else $error("empty packet result while output path busy");

	// A result without payload is always the final one of its packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_payload) |-> last)
		else $error("empty result not marked last");

	// A payload result lies inside its packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_payload) |-> ({1'b0, byte_index} < packet_length))
		else $error("byte index beyond packet length");

	// The final payload result carries the last position of the packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_payload && last) |->
		(({1'b0, byte_index} + LEN_W'(1)) == packet_length))
		else $error("last marker on wrong byte");
`endif

endmodule

>>> rtl/core/pdx_ctrl.sv
// Controller state machine of the packet deframer.
// Depends on pdx_pkg for the state type and the command and status structs.
module pdx_ctrl import pdx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    kind,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   acc;
	logic   byte_acc;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	// Input is held off during the emission run, and at the checksum while
	// results of the previous packet still wait in the output path.
	always_comb begin
		in_stall = 1'b0;
		if (state_q == ST_EMIT) begin
			in_stall = 1'b1;
		end else if (state_q == ST_CHECK && !sts.pipe_empty) begin
			in_stall = 1'b1;
		end
	end

	assign acc      = in_valid && !in_stall;
	assign byte_acc = acc && (kind == KIND_BYTE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_HUNT: begin
				if (byte_acc && sts.start_match) begin
					state_d = ST_ID_LO;
				end
			end
			ST_ID_LO: begin
				if (byte_acc) begin
					cmd.ld_id_lo = 1'b1;
					state_d      = ST_ID_HI;
				end
			end
			ST_ID_HI: begin
				if (byte_acc) begin
					cmd.ld_id_hi = 1'b1;
					state_d      = ST_LEN;
				end
			end
			ST_LEN: begin
				if (byte_acc) begin
					if (sts.len_bad) begin
						state_d = ST_HUNT;
					end else begin
						cmd.ld_len = 1'b1;
						state_d    = sts.rx_zero ? ST_CHECK : ST_DATA;
					end
				end
			end
			ST_DATA: begin
				if (byte_acc) begin
					cmd.st_data = 1'b1;
					if (sts.count_last) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (byte_acc) begin
					state_d = ST_HUNT;
					if (sts.xor_ok) begin
						if (sts.len_zero) begin
							cmd.emit_empty = 1'b1;
						end else begin
							cmd.emit_start = 1'b1;
							state_d        = ST_EMIT;
						end
					end
				end
			end
			ST_EMIT: begin
				cmd.rd_issue = sts.rd_ready;
				if (sts.rd_ready && sts.count_last) begin
					state_d = ST_HUNT;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase

		// A line error that is taken sends the parser back to the hunt from any phase.
		if (acc && kind == KIND_ERROR) begin
			state_d = ST_HUNT;
		end
	end

endmodule

>>> rtl/core/pdx_datapath.sv
// Datapath of the packet deframer: configuration registers, frame fields,
// running XOR, payload buffer, read stage and output register.
// Depends on pdx_pkg for sizes and the command and status structs.
module pdx_datapath import pdx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [BYTE_W-1:0] cfg_data,
	input  logic [BYTE_W-1:0] rx_data,
	input  cmd_t              cmd,
	output status_t           sts,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ID_W-1:0]   packet_id,
	output logic [LEN_W-1:0]  packet_length,
	output logic [ADDR_W-1:0] byte_index,
	output logic [BYTE_W-1:0] payload_byte,
	output logic              has_payload,
	output logic              last
);

	logic [BYTE_W-1:0] start_byte_q;
	logic [LEN_W-1:0]  max_len_q;
	logic [ID_W-1:0]   frame_id_q;
	logic [LEN_W-1:0]  frame_len_q;
	logic [LEN_W-1:0]  fill_q;
	logic [BYTE_W-1:0] xor_q;
	logic [BYTE_W-1:0] mem [PAYLOAD_DEPTH];

	logic              rd_valid_s1;
	logic [ADDR_W-1:0] rd_idx_s1;
	logic [BYTE_W-1:0] rd_data_s1;
	logic              rd_last_s1;
	logic [ID_W-1:0]   rd_id_s1;
	logic [LEN_W-1:0]  rd_len_s1;

	logic [LEN_W-1:0]  limit;
	logic [LEN_W-1:0]  fill_next;
	logic              out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			max_len_q    <= MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_START_BYTE: start_byte_q <= cfg_data;
				REG_MAX_LENGTH: max_len_q    <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// The effective length limit is capped by the buffer depth.
	assign limit = (max_len_q > LEN_W'(PAYLOAD_DEPTH)) ? LEN_W'(PAYLOAD_DEPTH) : max_len_q;
	assign fill_next = fill_q + LEN_W'(1);

	// Frame fields, running XOR and fill or emission count.
	always_ff @(posedge clk) begin
		if (cmd.ld_id_lo) begin
			frame_id_q[BYTE_W-1:0] <= rx_data;
			xor_q                  <= rx_data;
		end
		if (cmd.ld_id_hi) begin
			frame_id_q[ID_W-1:BYTE_W] <= rx_data;
			xor_q                     <= xor_q ^ rx_data;
		end
		if (cmd.ld_len) begin
			frame_len_q <= rx_data[LEN_W-1:0];
			xor_q       <= xor_q ^ rx_data;
			fill_q      <= '0;
		end
		if (cmd.st_data) begin
			xor_q  <= xor_q ^ rx_data;
			fill_q <= fill_next;
		end
		if (cmd.emit_start) begin
			fill_q <= '0;
		end
		if (cmd.rd_issue) begin
			fill_q <= fill_next;
		end
	end

	// Payload buffer: one write port for filling, one registered read port.
	// The read stage carries the id and length of its packet, since the next
	// frame may load new ones before a stalled byte has left.
	always_ff @(posedge clk) begin
		if (cmd.st_data) begin
			mem[fill_q[ADDR_W-1:0]] <= rx_data;
		end
		if (cmd.rd_issue) begin
			rd_data_s1 <= mem[fill_q[ADDR_W-1:0]];
			rd_idx_s1  <= fill_q[ADDR_W-1:0];
			rd_last_s1 <= (fill_next == frame_len_q);
			rd_id_s1   <= frame_id_q;
			rd_len_s1  <= frame_len_q;
		end
	end

	assign out_free = !out_valid || !out_stall;

	// Read stage occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else if (cmd.rd_issue) begin
			rd_valid_s1 <= 1'b1;
		end else if (out_free) begin
			rd_valid_s1 <= 1'b0;
		end
	end

	// Output register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= rd_valid_s1 || cmd.emit_empty;
		end
	end

	// Output payload: a buffered byte, or the single result of an empty packet.
	always_ff @(posedge clk) begin
		if (out_free && rd_valid_s1) begin
			packet_id     <= rd_id_s1;
			packet_length <= rd_len_s1;
			byte_index    <= rd_idx_s1;
			payload_byte  <= rd_data_s1;
			has_payload   <= 1'b1;
			last          <= rd_last_s1;
		end else if (out_free && cmd.emit_empty) begin
			packet_id     <= frame_id_q;
			packet_length <= frame_len_q;
			byte_index    <= '0;
			payload_byte  <= '0;
			has_payload   <= 1'b0;
			last          <= 1'b1;
		end
	end

	// Status towards the controller.
	always_comb begin
		sts.start_match = (rx_data == start_byte_q);
		sts.len_bad     = (rx_data > {1'b0, limit});
		sts.rx_zero     = (rx_data == '0);
		sts.len_zero    = (frame_len_q == '0);
		sts.count_last  = (fill_next == frame_len_q);
		sts.xor_ok      = (rx_data == xor_q);
		sts.rd_ready    = !rd_valid_s1 || out_free;
		sts.pipe_empty  = !rd_valid_s1 && !out_valid;
	end

endmodule
